// ----- rtl/mm_pkg.sv -----
// shared types, codes and defaults for the matrix multiply block
// no dependencies
`default_nettype none

package mm_pkg;

  localparam int DIM_W          = 4;   // size registers
  localparam int IDX_W          = 3;   // row and column fields
  localparam int SUM_W          = 35;  // q5.30 result
  localparam int MAX_DIM_DEF    = 8;
  localparam int ELEM_WIDTH_DEF = 16;

  typedef enum logic [1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_ROWS  = 2'd0,
    REG_INNER = 2'd1,
    REG_COLS  = 2'd2,
    REG_NONE  = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_RUN,
    SEQ_DRAIN
  } seq_state_e;

  // control that travels alongside one multiply-accumulate step
  typedef struct packed {
    logic             valid;
    logic             first;  // first step of a dot product
    logic             final_step;  // last step, result goes out
    logic             zero;   // empty inner dimension, product counts as zero
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;   // final element of the whole product
  } step_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
    clamp_dim = (v > lim) ? lim : v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mm_ram.sv -----
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
`default_nettype none

module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/mm_seq.sv -----
// compute sequencer: walks column, row and inner index, issues ram reads
// depends on mm_pkg
`default_nettype none

module mm_seq import mm_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF,
  localparam int AddrW = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,       // compute request accepted
  input  logic [DIM_W-1:0] nr_i,
  input  logic [DIM_W-1:0] nk_i,
  input  logic [DIM_W-1:0] nc_i,
  input  logic             pipe_busy_i,
  output logic             busy_o,
  output step_t            step_o,
  output logic [AddrW-1:0] raddr_a_o,
  output logic [AddrW-1:0] raddr_b_o
);

  seq_state_e state_q, state_d;
  logic [IDX_W-1:0] m_q, m_d, i_q, i_d, j_q, j_d;
  logic issue, zero_k, m_end, i_end, j_end;

  assign zero_k = (nk_i == '0);
  assign m_end  = zero_k || (({1'b0, m_q} + DIM_W'(1)) == nk_i);
  assign i_end  = (({1'b0, i_q} + DIM_W'(1)) == nr_i);
  assign j_end  = (({1'b0, j_q} + DIM_W'(1)) == nc_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      SEQ_IDLE: begin
        if (go_i && nr_i != '0 && nc_i != '0) begin
          state_d = SEQ_RUN;
        end
      end
      SEQ_RUN: begin
        if (m_end && i_end && j_end) begin
          state_d = SEQ_DRAIN;
        end
      end
      SEQ_DRAIN: begin
        if (!pipe_busy_i) begin
          state_d = SEQ_IDLE;
        end
      end
      default: state_d = SEQ_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    issue  = 1'b0;
    busy_o = 1'b1;
    case (state_q)
      SEQ_IDLE:  busy_o = 1'b0;
      SEQ_RUN:   issue  = 1'b1;
      SEQ_DRAIN: issue  = 1'b0;
      default:   busy_o = 1'b1;
    endcase
  end

  always_comb begin
    m_d = m_q;
    i_d = i_q;
    j_d = j_q;
    if (state_q == SEQ_IDLE) begin
      m_d = '0;
      i_d = '0;
      j_d = '0;
    end else if (issue) begin
      if (m_end) begin
        m_d = '0;
        if (i_end) begin
          i_d = '0;
          j_d = j_q + IDX_W'(1);
        end else begin
          i_d = i_q + IDX_W'(1);
        end
      end else begin
        m_d = m_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      m_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      m_q     <= m_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  assign step_o.valid      = issue;
  assign step_o.first      = (m_q == '0);
  assign step_o.final_step = m_end;
  assign step_o.zero       = zero_k;
  assign step_o.row        = i_q;
  assign step_o.col        = j_q;
  assign step_o.last       = m_end && i_end && j_end;

  assign raddr_a_o = AddrW'(int'(i_q) * MAX_DIM + int'(m_q));
  assign raddr_b_o = AddrW'(int'(m_q) * MAX_DIM + int'(j_q));

endmodule

`default_nettype wire

// ----- rtl/mm_mac.sv -----
// multiply-accumulate datapath: product stage, accumulator, result register
// depends on mm_pkg
`default_nettype none

module mm_mac import mm_pkg::*; #(
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  step_t                 step_i,
  input  logic [ELEM_WIDTH-1:0] a_i,   // ram data, arrives in the cycle after issue
  input  logic [ELEM_WIDTH-1:0] b_i,
  output logic                  pipe_busy_o,
  output logic                  out_valid_o,
  output logic [IDX_W-1:0]      out_row_o,
  output logic [IDX_W-1:0]      out_col_o,
  output logic [SUM_W-1:0]      sum_o,
  output logic                  last_o
);

  localparam int ProdW = 2 * ELEM_WIDTH;
  localparam int ExtW  = (ProdW > SUM_W) ? ProdW : SUM_W;

  step_t s1_q, s2_q;
  logic signed [ProdW-1:0] prod;
  logic signed [ExtW-1:0]  prod_ext;
  logic [SUM_W-1:0] prod_d, prod_q, acc_q, sum_d;
  logic out_valid_q, last_q;
  logic [IDX_W-1:0] row_q, col_q;
  logic [SUM_W-1:0] sum_q;

  assign prod     = $signed(a_i) * $signed(b_i);
  assign prod_ext = ExtW'(prod);
  // sums wrap modulo 2^35
  assign prod_d   = s1_q.zero ? '0 : prod_ext[SUM_W-1:0];
  assign sum_d    = s2_q.first ? prod_q : acc_q + prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      s2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_q        <= step_i;
      s2_q        <= s1_q;
      out_valid_q <= s2_q.valid && s2_q.final_step;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (s2_q.valid) begin
      acc_q <= sum_d;
    end
    if (s2_q.valid && s2_q.final_step) begin
      sum_q  <= sum_d;
      row_q  <= s2_q.row;
      col_q  <= s2_q.col;
      last_q <= s2_q.last;
    end
  end

  assign pipe_busy_o = s1_q.valid || s2_q.valid;
  assign out_valid_o = out_valid_q;
  assign out_row_o   = row_q;
  assign out_col_o   = col_q;
  assign sum_o       = sum_q;
  assign last_o      = out_valid_q && last_q;

endmodule

`default_nettype wire

// ----- rtl/matrix_multiply.sv -----
// matrix multiply top level: size registers, element stores, sequencer, mac
// depends on mm_pkg, mm_ram, mm_seq, mm_mac
//
// channel   signals                                             direction
// request   start, busy, operation_i, row_index_i, col_index_i,
//           element_value_i                                     in
// result    out_valid_o, out_row_o, out_col_o, sum_value_o,
//           last_element_o                                      out
// config    cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i   in
//
// a load request writes at most one ram entry; busy stays low.
// a compute request keeps busy high while max(inner,1)*rows*cols read pairs
// issue, one ram read pair per cycle, and while the pipeline drains.
// results pass the ram read, product and result registers after their last read, one strobe per element.
// reset clears the size registers to 8 and the control; the stores are not
// cleared. the receiver cannot stall, config is always ready.
`default_nettype none

module matrix_multiply import mm_pkg::*; #(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            operation_i,
  input  logic [IDX_W-1:0]      row_index_i,
  input  logic [IDX_W-1:0]      col_index_i,
  input  logic [ELEM_WIDTH-1:0] element_value_i,
  output logic                  out_valid_o,
  output logic [IDX_W-1:0]      out_row_o,
  output logic [IDX_W-1:0]      out_col_o,
  output logic [SUM_W-1:0]      sum_value_o,
  output logic                  last_element_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [DIM_W-1:0]      cfg_data_i
);

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [DIM_W-1:0] rows_q, inner_q, cols_q;
  logic [DIM_W-1:0] nr, nk, nc;
  logic accept, go, we_a, we_b, pipe_busy;
  logic [AddrW-1:0] waddr, raddr_a, raddr_b;
  logic [ELEM_WIDTH-1:0] rdata_a, rdata_b;
  step_t step;
  op_e op;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DIM_W'(8);
      inner_q <= DIM_W'(8);
      cols_q  <= DIM_W'(8);
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_ROWS:  rows_q  <= cfg_data_i;
        REG_INNER: inner_q <= cfg_data_i;
        REG_COLS:  cols_q  <= cfg_data_i;
        default:   rows_q  <= rows_q;
      endcase
    end
  end

  assign nr = clamp_dim(rows_q, DIM_W'(MAX_DIM));
  assign nk = clamp_dim(inner_q, DIM_W'(MAX_DIM));
  assign nc = clamp_dim(cols_q, DIM_W'(MAX_DIM));

  assign op     = op_e'(operation_i);
  assign accept = start && !busy;
  assign go     = accept && (op == OP_COMPUTE);
  // writes outside the configured sizes are dropped
  assign we_a   = accept && (op == OP_WRITE_A) &&
                  ({1'b0, row_index_i} < nr) && ({1'b0, col_index_i} < nk);
  assign we_b   = accept && (op == OP_WRITE_B) &&
                  ({1'b0, row_index_i} < nk) && ({1'b0, col_index_i} < nc);
  assign waddr  = AddrW'(int'(row_index_i) * MAX_DIM + int'(col_index_i));

  mm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(Depth)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  mm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(Depth)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  mm_seq #(.MAX_DIM(MAX_DIM)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go),
    .nr_i        (nr),
    .nk_i        (nk),
    .nc_i        (nc),
    .pipe_busy_i (pipe_busy),
    .busy_o      (busy),
    .step_o      (step),
    .raddr_a_o   (raddr_a),
    .raddr_b_o   (raddr_b)
  );

  mm_mac #(.ELEM_WIDTH(ELEM_WIDTH)) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .a_i         (rdata_a),
    .b_i         (rdata_b),
    .pipe_busy_o (pipe_busy),
    .out_valid_o (out_valid_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .sum_o       (sum_value_o),
    .last_o      (last_element_o)
  );

  // stores are never written while a compute reads them
  a_no_write_in_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we_a || we_b) |-> !busy)
    else $error("element write during compute");

  // busy only rises after an accepted request
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  // the final element ends a product, no result directly follows it
  a_last_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_element_o |=> !out_valid_o)
    else $error("result right after final element");

  // last flag only appears with the strobe
  a_last_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_element_o |-> out_valid_o && $past(busy))
    else $error("last flag without a result");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking bench for matrix_multiply: loads, products and size settings
// depends on mm_pkg and the matrix_multiply rtl; holds its own gemm predictor
`timescale 1ns / 1ps

module testbench;
  import mm_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int EW          = ELEM_WIDTH_DEF;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [SUM_W-1:0] sum;
    logic             last;
  } product_elem_t;

  class gemm_scoreboard;
    product_elem_t    pending[$];
    logic [DIM_W-1:0] size_reg [3];
    logic [EW-1:0]    a_elem [8][8];
    logic [EW-1:0]    b_elem [8][8];
    bit               a_known [8][8];
    bit               b_known [8][8];
    int               errors;

    function new();
      for (int i = 0; i < 3; i++) size_reg[i] = 4'd8;
      for (int r = 0; r < 8; r++) begin
        for (int c = 0; c < 8; c++) begin
          a_known[r][c] = 1'b0;
          b_known[r][c] = 1'b0;
        end
      end
      errors = 0;
    endfunction

    // sizes above the maximum behave as the maximum
    function int dim(reg_e idx);
      int v;
      v = size_reg[idx];
      return (v > MAX_DIM_DEF) ? MAX_DIM_DEF : v;
    endfunction

    function void write_size(logic [1:0] idx, logic [DIM_W-1:0] data);
      if (idx != REG_NONE) size_reg[idx] = data;
    endfunction

    function void accept_request(logic [1:0] op, logic [IDX_W-1:0] row,
                                 logic [IDX_W-1:0] col, logic [EW-1:0] val);
      int            nr, nk, nc;
      longint        acc;
      product_elem_t e;
      nr = dim(REG_ROWS);
      nk = dim(REG_INNER);
      nc = dim(REG_COLS);
      case (op)
        OP_WRITE_A: begin
          if (row < nr && col < nk) begin
            a_elem[row][col]  = val;
            a_known[row][col] = 1'b1;
          end
        end
        OP_WRITE_B: begin
          if (row < nk && col < nc) begin
            b_elem[row][col]  = val;
            b_known[row][col] = 1'b1;
          end
        end
        OP_COMPUTE: begin
          // column outer, row inner
          for (int j = 0; j < nc; j++) begin
            for (int i = 0; i < nr; i++) begin
              acc = 0;
              for (int m = 0; m < nk; m++)
                acc += longint'($signed(a_elem[i][m])) * longint'($signed(b_elem[m][j]));
              e.row  = IDX_W'(i);
              e.col  = IDX_W'(j);
              e.sum  = acc[SUM_W-1:0];
              e.last = (j == nc - 1) && (i == nr - 1);
              pending.push_back(e);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_element(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                logic [SUM_W-1:0] sum, logic last);
      product_elem_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result row %0d col %0d sum %h last %b",
                 $time, row, col, sum, last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if ({row, col, sum, last} !== {e.row, e.col, e.sum, e.last}) begin
        $display("%0t: mismatch expected row %0d col %0d sum %h last %b,",
                 $time, e.row, e.col, e.sum, e.last,
                 " got row %0d col %0d sum %h last %b", row, col, sum, last);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [1:0]       operation;
  logic [IDX_W-1:0] row_index;
  logic [IDX_W-1:0] col_index;
  logic [EW-1:0]    element_value;
  logic             out_valid;
  logic [IDX_W-1:0] out_row;
  logic [IDX_W-1:0] out_col;
  logic [SUM_W-1:0] sum_value;
  logic             last_element;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [DIM_W-1:0] cfg_data;

  gemm_scoreboard sb;
  bit             req_fire;
  bit             cfg_fire;
  bit             busy_seen;
  int             idle_pct;
  int             cycles;

  matrix_multiply uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation),
    .row_index_i     (row_index),
    .col_index_i     (col_index),
    .element_value_i (element_value),
    .out_valid_o     (out_valid),
    .out_row_o       (out_row),
    .out_col_o       (out_col),
    .sum_value_o     (sum_value),
    .last_element_o  (last_element),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // sample mid-cycle; what is seen here is what the next rising edge takes
  always @(negedge clk) begin
    if (rst_n) begin
      req_fire  = start && !busy;
      cfg_fire  = cfg_valid && cfg_ready;
      busy_seen = busy;
      if (out_valid) sb.check_element(out_row, out_col, sum_value, last_element);
      if (cfg_fire) sb.write_size(cfg_index, cfg_data);
      if (req_fire) sb.accept_request(operation, row_index, col_index, element_value);
    end else begin
      req_fire  = 1'b0;
      cfg_fire  = 1'b0;
      busy_seen = 1'b0;
    end
  end

  function automatic logic [EW-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return EW'($urandom);
    endcase
  endfunction

  function automatic int rand_dim();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r < 3) return $urandom_range(9, 15);
    return $urandom_range(1, 8);
  endfunction

  // each cycle idles with the same odds, so idle_pct is the idle share of cycles
  task automatic maybe_idle();
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  // start stays high on return, so a following request goes out back to back
  task automatic send_request(op_e op, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                              logic [EW-1:0] val);
    maybe_idle();
    start         <= 1'b1;
    operation     <= op;
    row_index     <= row;
    col_index     <= col;
    element_value <= val;
    @(posedge clk);
    while (!req_fire) @(posedge clk);
  endtask

  task automatic write_reg(reg_e idx, logic [DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_fire) @(posedge clk);
  endtask

  task automatic configure(int rows, int inner, int cols, bit with_spare);
    write_reg(REG_ROWS, DIM_W'(rows));
    write_reg(REG_INNER, DIM_W'(inner));
    write_reg(REG_COLS, DIM_W'(cols));
    if (with_spare) write_reg(REG_NONE, DIM_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // hold off until every expected element is out and the block has gone quiet
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0 || busy_seen);
    repeat (8) @(posedge clk);
  endtask

  // a product must never read an element that was not loaded
  task automatic fill_missing();
    int nr, nk, nc;
    nr = sb.dim(REG_ROWS);
    nk = sb.dim(REG_INNER);
    nc = sb.dim(REG_COLS);
    if (nr == 0 || nc == 0) return;
    for (int r = 0; r < nr; r++)
      for (int k = 0; k < nk; k++)
        if (!sb.a_known[r][k]) send_request(OP_WRITE_A, IDX_W'(r), IDX_W'(k), rand_elem());
    for (int k = 0; k < nk; k++)
      for (int c = 0; c < nc; c++)
        if (!sb.b_known[k][c]) send_request(OP_WRITE_B, IDX_W'(k), IDX_W'(c), rand_elem());
  endtask

  task automatic compute_product();
    fill_missing();
    send_request(OP_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), EW'($urandom));
  endtask

  task automatic random_request();
    int pick, nr, nk, nc;
    pick = $urandom_range(0, 99);
    nr   = sb.dim(REG_ROWS);
    nk   = sb.dim(REG_INNER);
    nc   = sb.dim(REG_COLS);
    if (pick < 12) begin
      compute_product();
      if ($urandom_range(0, 9) == 0) wait_idle();
    end else if (pick < 80) begin
      if ($urandom_range(0, 1) == 1 && nr > 0 && nk > 0)
        send_request(OP_WRITE_A, IDX_W'($urandom_range(0, nr - 1)),
                     IDX_W'($urandom_range(0, nk - 1)), rand_elem());
      else if (nk > 0 && nc > 0)
        send_request(OP_WRITE_B, IDX_W'($urandom_range(0, nk - 1)),
                     IDX_W'($urandom_range(0, nc - 1)), rand_elem());
      else
        send_request(OP_WRITE_A, IDX_W'($urandom), IDX_W'($urandom), rand_elem());
    end else if (pick < 92) begin
      // any index, mostly out of range for small sizes
      send_request($urandom_range(0, 1) ? OP_WRITE_B : OP_WRITE_A,
                   IDX_W'($urandom), IDX_W'($urandom), rand_elem());
    end else begin
      send_request(OP_NONE, IDX_W'($urandom), IDX_W'($urandom), EW'($urandom));
    end
  endtask

  initial begin
    sb            = new();
    cycles        = 0;
    idle_pct      = 0;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    operation     <= OP_NONE;
    row_index     <= '0;
    col_index     <= '0;
    element_value <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_NONE;
    cfg_data      <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // largest positive sum: eight products of the most negative values
    configure(1, 8, 1, 1'b1);
    for (int m = 0; m < 8; m++) begin
      send_request(OP_WRITE_A, 3'd0, IDX_W'(m), 16'h8000);
      send_request(OP_WRITE_B, IDX_W'(m), 3'd0, 16'h8000);
    end
    compute_product();
    wait_idle();

    // out-of-range writes and the unused operation change nothing
    configure(1, 1, 1, 1'b0);
    send_request(OP_WRITE_A, 3'd0, 3'd0, 16'h7fff);
    compute_product();
    send_request(OP_WRITE_A, 3'd1, 3'd0, 16'h1234);
    send_request(OP_WRITE_B, 3'd0, 3'd1, 16'h4321);
    send_request(OP_WRITE_A, 3'd7, 3'd7, 16'hffff);
    send_request(OP_WRITE_B, 3'd7, 3'd7, 16'h0001);
    send_request(OP_NONE, 3'd7, 3'd7, 16'hffff);
    compute_product();
    wait_idle();

    // empty inner dimension gives zero sums, empty rows or cols give nothing
    configure(1, 0, 1, 1'b0);
    compute_product();
    wait_idle();
    configure(0, 8, 8, 1'b0);
    compute_product();
    wait_idle();
    configure(4, 3, 0, 1'b0);
    compute_product();
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       configure(15, 12, 9, 1'b0);
        1:       configure(8, 8, 8, 1'b0);
        2:       configure(1, 1, 1, 1'b0);
        3:       configure(3, 0, 6, 1'b0);
        default: configure(rand_dim(), rand_dim(), rand_dim(), 1'b0);
      endcase
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 72;
        default: idle_pct = 8;
      endcase
      repeat (36) random_request();
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
